/* hw/rtl/bsdpb_pkg.sv */
package bsdpb_pkg;

  localparam int SectorBytes = 36;
  localparam int FirstKept   = 11;
  localparam int KeptCount   = 25;
  localparam int ResultCount = 20;
  localparam int KeptIdxW    = $clog2(KeptCount);
  localparam int OutIdxW     = $clog2(ResultCount);
  localparam int CountW      = $clog2(SectorBytes);

  // Controller to datapath commands.
  typedef struct packed {
    logic                save_addr;
    logic                cap_en;
    logic [KeptIdxW-1:0] cap_idx;
    logic                ld_mul;
    logic                div_start;
    logic                div_sel;
    logic                ld_dirsec;
    logic                ld_firrec;
    logic                ld_maxclus;
    logic                out_load;
    logic [OutIdxW-1:0]  out_idx;
    logic                out_last;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } dp_status_t;

  // Number of consecutive one bits starting at bit zero.
  function automatic logic [3:0] trailing_ones(input logic [7:0] v);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 0; i < 8; i++) begin
      run = run & v[i];
      n   = n + {3'd0, run};
    end
    return n;
  endfunction

endpackage

/* hw/rtl/bsdpb_div.sv */
module bsdpb_div import bsdpb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic [15:0] quot_o,
  output logic        done_o
);

  // Restoring division, one quotient bit per cycle. The dividend shifts out of
  // the top of quo_q while quotient bits shift in at the bottom.
  logic [31:0] quo_q, quo_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] dvs_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[31]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = rem_sh >= {1'b0, dvs_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = 16'd0;
      quo_d  = dividend_i;
      cnt_d  = 5'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[15:0] : rem_sh[15:0];
      quo_d = {quo_q[30:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign quot_o = quo_q[15:0];
  assign done_o = done_q;

endmodule

/* hw/rtl/bsdpb_dp.sv */
module bsdpb_dp import bsdpb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  logic [7:0]  sector_byte_i,
  input  logic [15:0] dest_address_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);

  // Result byte positions.
  localparam logic [OutIdxW-1:0] OB_ADDR_LO  = 5'd0;
  localparam logic [OutIdxW-1:0] OB_ADDR_HI  = 5'd1;
  localparam logic [OutIdxW-1:0] OB_MEDIA    = 5'd2;
  localparam logic [OutIdxW-1:0] OB_SECSZ_LO = 5'd3;
  localparam logic [OutIdxW-1:0] OB_SECSZ_HI = 5'd4;
  localparam logic [OutIdxW-1:0] OB_DIRMSK   = 5'd5;
  localparam logic [OutIdxW-1:0] OB_DIRSHFT  = 5'd6;
  localparam logic [OutIdxW-1:0] OB_CLUSMSK  = 5'd7;
  localparam logic [OutIdxW-1:0] OB_CLUSSHFT = 5'd8;
  localparam logic [OutIdxW-1:0] OB_FIRFAT_LO = 5'd9;
  localparam logic [OutIdxW-1:0] OB_FIRFAT_HI = 5'd10;
  localparam logic [OutIdxW-1:0] OB_FATCNT   = 5'd11;
  localparam logic [OutIdxW-1:0] OB_MAXENT   = 5'd12;
  localparam logic [OutIdxW-1:0] OB_FIRREC_LO = 5'd13;
  localparam logic [OutIdxW-1:0] OB_FIRREC_HI = 5'd14;
  localparam logic [OutIdxW-1:0] OB_MAXCL_LO = 5'd15;
  localparam logic [OutIdxW-1:0] OB_MAXCL_HI = 5'd16;
  localparam logic [OutIdxW-1:0] OB_FATSIZ   = 5'd17;
  localparam logic [OutIdxW-1:0] OB_FIRDIR_LO = 5'd18;
  localparam logic [OutIdxW-1:0] OB_FIRDIR_HI = 5'd19;

  logic [7:0]  cf_q [KeptCount];
  logic [15:0] addr_q;
  logic [15:0] firdir_q;
  logic [27:0] prod_q;
  logic [15:0] dirsec_q;
  logic [15:0] firrec_q;
  logic [15:0] maxclus_q;
  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q;
  logic        olast_q;

  logic [15:0] bps, ffs, rde, ns_raw, ns, spf, ns32_lo;
  logic [7:0]  spc, nf, media;
  logic [7:0]  dirmsk, clusmsk;
  logic [23:0] nf_spf;
  logic [16:0] diff;
  logic        diff_neg;
  logic [16:0] diff_mag;
  logic [31:0] div_dividend;
  logic [15:0] div_divisor;
  logic [15:0] div_quot;
  logic        div_done;
  logic [15:0] quot_signed;
  logic [7:0]  obyte_d;

  always_comb begin
    bps     = {cf_q[1], cf_q[0]};
    spc     = cf_q[2];
    ffs     = {cf_q[4], cf_q[3]};
    nf      = cf_q[5];
    rde     = {cf_q[7], cf_q[6]};
    ns_raw  = {cf_q[9], cf_q[8]};
    media   = cf_q[10];
    spf     = {cf_q[12], cf_q[11]};
    ns32_lo = {cf_q[22], cf_q[21]};
    ns      = (ns_raw == 16'd0) ? ns32_lo : ns_raw;
    nf_spf  = nf * spf;
    dirmsk  = bps[12:5] - 8'd1;
    clusmsk = spc - 8'd1;
    // Signed sectors left after the fixed area, divided by magnitude.
    diff     = {1'b0, ns} - {1'b0, firrec_q};
    diff_neg = diff[16];
    diff_mag = diff_neg ? (17'd0 - diff) : diff;
    if (cmd_i.div_sel) begin
      div_dividend = {15'd0, diff_mag};
      div_divisor  = {8'd0, spc};
    end else begin
      div_dividend = {4'd0, prod_q};
      div_divisor  = bps;
    end
    if (spc == 8'd0) begin
      quot_signed = 16'hFFFF;
    end else begin
      quot_signed = diff_neg ? (16'd0 - div_quot) : div_quot;
    end
  end

  bsdpb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  always_comb begin
    unique case (cmd_i.out_idx)
      OB_ADDR_LO:   obyte_d = addr_q[7:0];
      OB_ADDR_HI:   obyte_d = addr_q[15:8];
      OB_MEDIA:     obyte_d = media;
      OB_SECSZ_LO:  obyte_d = bps[7:0];
      OB_SECSZ_HI:  obyte_d = bps[15:8];
      OB_DIRMSK:    obyte_d = dirmsk;
      OB_DIRSHFT:   obyte_d = {4'd0, trailing_ones(dirmsk)};
      OB_CLUSMSK:   obyte_d = clusmsk;
      OB_CLUSSHFT:  obyte_d = {4'd0, trailing_ones(clusmsk)} + 8'd1;
      OB_FIRFAT_LO: obyte_d = ffs[7:0];
      OB_FIRFAT_HI: obyte_d = ffs[15:8];
      OB_FATCNT:    obyte_d = nf;
      OB_MAXENT:    obyte_d = rde[7:0];
      OB_FIRREC_LO: obyte_d = firrec_q[7:0];
      OB_FIRREC_HI: obyte_d = firrec_q[15:8];
      OB_MAXCL_LO:  obyte_d = maxclus_q[7:0];
      OB_MAXCL_HI:  obyte_d = maxclus_q[15:8];
      OB_FATSIZ:    obyte_d = spf[7:0];
      OB_FIRDIR_LO: obyte_d = firdir_q[7:0];
      OB_FIRDIR_HI: obyte_d = firdir_q[15:8];
      default:      obyte_d = 8'd0;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      addr_q   <= 16'd0;
    end else begin
      ovalid_q <= ovalid_d;
      if (cmd_i.save_addr) begin
        addr_q <= dest_address_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      cf_q[cmd_i.cap_idx] <= sector_byte_i;
    end
    if (cmd_i.ld_mul) begin
      firdir_q <= ffs + nf_spf[15:0];
      prod_q   <= rde * bps[15:4];
    end
    if (cmd_i.ld_dirsec) begin
      dirsec_q <= (bps == 16'd0) ? 16'hFFFF : div_quot;
    end
    if (cmd_i.ld_firrec) begin
      firrec_q <= firdir_q + dirsec_q;
    end
    if (cmd_i.ld_maxclus) begin
      maxclus_q <= quot_signed + 16'd1;
    end
    if (cmd_i.out_load) begin
      obyte_q <= obyte_d;
      olast_q <= cmd_i.out_last;
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o       = ovalid_q;
  assign out_byte_o        = obyte_q;
  assign out_last_o        = olast_q;

endmodule

/* hw/rtl/bsdpb_ctrl.sv */
module bsdpb_ctrl import bsdpb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] S_CAP       = 3'd0;
  localparam logic [2:0] S_MUL       = 3'd1;
  localparam logic [2:0] S_DIV1_GO   = 3'd2;
  localparam logic [2:0] S_DIV1_WAIT = 3'd3;
  localparam logic [2:0] S_SUM       = 3'd4;
  localparam logic [2:0] S_DIV2_GO   = 3'd5;
  localparam logic [2:0] S_DIV2_WAIT = 3'd6;
  localparam logic [2:0] S_EMIT      = 3'd7;

  localparam logic [CountW-1:0]  LastOffset = CountW'(SectorBytes - 1);
  localparam logic [CountW-1:0]  KeptStart  = CountW'(FirstKept);
  localparam logic [OutIdxW-1:0] LastOut    = OutIdxW'(ResultCount - 1);

  logic [2:0]         state_q, state_d;
  logic [CountW-1:0]  count_q, count_d;
  logic [OutIdxW-1:0] oidx_q, oidx_d;
  logic [CountW-1:0]  kept_off;
  logic               accept;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    oidx_d   = oidx_q;
    cmd_o    = '0;
    accept   = in_valid_i && (state_q == S_CAP);
    kept_off = count_q - KeptStart;
    cmd_o.cap_idx = kept_off[KeptIdxW-1:0];
    cmd_o.out_idx = oidx_q;
    unique case (state_q)
      S_CAP: begin
        if (accept) begin
          cmd_o.save_addr = (count_q == '0);
          cmd_o.cap_en    = (count_q >= KeptStart);
          if (count_q == LastOffset) begin
            count_d = '0;
            state_d = S_MUL;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd_o.ld_mul = 1'b1;
        state_d      = S_DIV1_GO;
      end
      S_DIV1_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV1_WAIT;
      end
      S_DIV1_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.ld_dirsec = 1'b1;
          state_d         = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.ld_firrec = 1'b1;
        state_d         = S_DIV2_GO;
      end
      S_DIV2_GO: begin
        cmd_o.div_sel   = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV2_WAIT;
      end
      S_DIV2_WAIT: begin
        cmd_o.div_sel = 1'b1;
        if (status_i.div_done) begin
          cmd_o.ld_maxclus = 1'b1;
          oidx_d           = '0;
          state_d          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = (oidx_q == LastOut);
          if (oidx_q == LastOut) begin
            state_d = S_CAP;
          end else begin
            oidx_d = oidx_q + 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CAP;
      count_q <= '0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      oidx_q  <= oidx_d;
    end
  end

  assign in_ready_o = (state_q == S_CAP);

endmodule

/* hw/rtl/boot_sector_to_dpb_builder.sv */
// Takes 36 boot sector bytes, one item per cycle while input is accepted.
// After the last byte the controller runs the multiply, first division, sum and
// second division; both bit-serial divisions share a single divider. The 20
// result items then follow at one per cycle while the output is ready, and no
// new sector is accepted until the last result item has been loaded.
// Reset clears the byte counter, the saved address and the output valid flag.
module boot_sector_to_dpb_builder import bsdpb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // [7:0] sector_byte, [23:8] dest_address
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [7:0] out_byte
  output logic        m_axis_tlast_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bsdpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bsdpb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sector_byte_i  (s_axis_tdata_i[7:0]),
    .dest_address_i (s_axis_tdata_i[23:8]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .out_byte_o     (m_axis_tdata_o),
    .out_last_o     (m_axis_tlast_o)
  );

  // A result item is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

  // No result is produced while input bytes are being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !cmd.out_load)
    else $error("result load during capture");

  // After the last result item the block is ready for a new sector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && cmd.out_last) |=> s_axis_tready_o)
    else $error("no return to capture after last item");

endmodule
